### design/khce_pkg.sv
package khce_pkg;

  // One keyframe as it sits in the key table.
  typedef struct packed {
    logic signed [31:0] key_time;
    logic signed [31:0] key_value;
    logic signed [31:0] tangent_in;
    logic signed [31:0] tangent_out;
  } key_t;

  localparam int KEY_W = $bits(key_t);

  // Payload of one input transfer.
  typedef struct packed {
    logic              opcode;
    logic [5:0]        key_index;
    logic signed [31:0] key_time;
    logic signed [31:0] key_value;
    logic signed [31:0] tangent_in;
    logic signed [31:0] tangent_out;
    logic signed [31:0] query_time;
  } item_t;

  // Input opcodes
  localparam logic OPC_LOAD  = 1'b0;
  localparam logic OPC_QUERY = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_ZLEN = 2'd2;

  // Datapath operations
  typedef logic [4:0] op_t;
  localparam op_t OP_NONE  = 5'd0;
  localparam op_t OP_LOAD  = 5'd1;
  localparam op_t OP_START = 5'd2;
  localparam op_t OP_ZERO  = 5'd3;
  localparam op_t OP_SMALL = 5'd4;
  localparam op_t OP_K0    = 5'd5;
  localparam op_t OP_K1    = 5'd6;
  localparam op_t OP_PREP  = 5'd7;
  localparam op_t OP_HZ    = 5'd8;
  localparam op_t OP_DIV   = 5'd9;
  localparam op_t OP_SFIN  = 5'd10;
  localparam op_t OP_M0    = 5'd11;
  localparam op_t OP_M1    = 5'd12;
  localparam op_t OP_M1L   = 5'd13;
  localparam op_t OP_COEF  = 5'd14;
  localparam op_t OP_HABS  = 5'd15;
  localparam op_t OP_HLO   = 5'd16;
  localparam op_t OP_HHI   = 5'd17;
  localparam op_t OP_HCMB  = 5'd18;
  localparam op_t OP_HADD  = 5'd19;
  localparam op_t OP_FIN   = 5'd20;

  // Horner step: which term gets added after the product
  typedef logic [1:0] step_t;
  localparam step_t STEP_C2 = 2'd0;
  localparam step_t STEP_M0 = 2'd1;
  localparam step_t STEP_V0 = 2'd2;

  typedef struct packed {
    op_t   op;
    step_t step;
  } cmd_t;

  typedef struct packed {
    logic found;   // key time at or after query time
    logic h_zero;  // zero-length segment
  } sts_t;

  localparam int DIV_BITS = 49;  // |dt| * 2^16 dividend
  localparam logic signed [63:0] SAT_LIM  = 64'sh2000_0000_0000_0000;
  localparam logic [63:0]        PH_LIM   = 64'h0000_2000_0000_0000;
  localparam logic [48:0]        S_LIM    = 49'h0_0000_8000_0000;
  localparam logic signed [63:0] I32_MAX  = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] I32_MIN  = -64'sh0000_0000_8000_0000;

endpackage

### design/khce_if.sv
interface khce_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [5:0]         key_index;
  logic signed [31:0] key_time;
  logic signed [31:0] key_value;
  logic signed [31:0] tangent_in;
  logic signed [31:0] tangent_out;
  logic signed [31:0] query_time;

  modport source (output valid, opcode, key_index, key_time, key_value, tangent_in,
                  tangent_out, query_time, input ready);
  modport sink (input valid, opcode, key_index, key_time, key_value, tangent_in,
                tangent_out, query_time, output ready);
endinterface

interface khce_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] curve_value;
  logic [1:0]         status;

  modport source (output valid, curve_value, status, input ready);
  modport sink (input valid, curve_value, status, output ready);
endinterface

### design/khce_ram.sv
module khce_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/khce_dp.sv
module khce_dp #(
  parameter int MAX_KEYS = 64,
  localparam int AW = $clog2(MAX_KEYS)
) (
  input  logic                clk,
  input  khce_pkg::cmd_t      cmd,
  input  logic [AW-1:0]       raddr,
  input  khce_pkg::item_t     item,
  output khce_pkg::sts_t      sts,
  output logic signed [31:0]  curve_value,
  output logic [1:0]          status
);

  function automatic logic [31:0] mag32(logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

  logic [khce_pkg::KEY_W-1:0] rdata;
  khce_pkg::key_t             rd_key;
  khce_pkg::key_t             wr_key;
  logic                       we;

  assign wr_key = '{key_time: item.key_time, key_value: item.key_value,
                    tangent_in: item.tangent_in, tangent_out: item.tangent_out};
  assign we = (cmd.op == khce_pkg::OP_LOAD) && (int'(item.key_index) < MAX_KEYS);
  assign rd_key = khce_pkg::key_t'(rdata);

  khce_ram #(.WIDTH(khce_pkg::KEY_W), .DEPTH(MAX_KEYS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(item.key_index)),
    .wdata (wr_key),
    .raddr (raddr),
    .rdata (rdata)
  );

  logic signed [31:0] t_r, t0_r, v0_r, tout0_r, t1_r, v1_r, tin1_r;
  logic               h_neg_r, q_neg_r, s_neg_r, a_neg_r;
  logic [32:0]        hmag_r, rem_r;
  logic [48:0]        q_r;
  logic [31:0]        smag_r;
  logic [64:0]        prod_r;
  logic [63:0]        pl_r;
  logic [61:0]        amag_r;
  logic signed [63:0] m0_r, m1_r, c2_r, acc_r, term_r;
  logic signed [31:0] curve_r;
  logic [1:0]         status_r;

  // combinational helpers
  logic signed [32:0] h_full, dt_full;
  logic [32:0]        h_mag, dt_mag;
  logic [33:0]        rem_sh;
  logic               div_ge;
  logic [32:0]        mul_a;
  logic [31:0]        mul_b;
  logic [64:0]        mul_p;
  logic signed [63:0] p16, d, v0x, v1x, addend, sum;
  logic [63:0]        r_mag;

  assign h_full  = {t1_r[31], t1_r} - {t0_r[31], t0_r};
  assign dt_full = {t_r[31], t_r} - {t0_r[31], t0_r};
  assign h_mag   = h_full[32] ? 33'(-h_full) : 33'(h_full);
  assign dt_mag  = dt_full[32] ? 33'(-dt_full) : 33'(dt_full);

  // restoring divide, one quotient bit a cycle
  assign rem_sh = {rem_r, q_r[48]};
  assign div_ge = rem_sh >= {1'b0, hmag_r};

  always_comb begin
    case (cmd.op)
      khce_pkg::OP_M0: begin
        mul_a = hmag_r;
        mul_b = mag32(tout0_r);
      end
      khce_pkg::OP_M1: begin
        mul_a = hmag_r;
        mul_b = mag32(tin1_r);
      end
      khce_pkg::OP_HLO: begin
        mul_a = {1'b0, amag_r[31:0]};
        mul_b = smag_r;
      end
      khce_pkg::OP_HHI: begin
        mul_a = {3'b0, amag_r[61:32]};
        mul_b = smag_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 65'(mul_a) * 65'(mul_b);
  assign p16   = signed'(64'(prod_r[64:16]));
  assign v0x   = 64'(v0_r);
  assign v1x   = 64'(v1_r);
  assign d     = v1x - v0x;

  // combine partial products of the Q16.16 multiply, saturated at 2^61
  always_comb begin
    if (prod_r[63:0] >= khce_pkg::PH_LIM) begin
      r_mag = 64'(khce_pkg::SAT_LIM);
    end else begin
      r_mag = (prod_r[63:0] << 16) + (pl_r >> 16);
      if (r_mag > 64'(khce_pkg::SAT_LIM)) begin
        r_mag = 64'(khce_pkg::SAT_LIM);
      end
    end
  end

  always_comb begin
    case (cmd.step)
      khce_pkg::STEP_C2: addend = c2_r;
      khce_pkg::STEP_M0: addend = m0_r;
      default:           addend = v0x;
    endcase
    sum = addend + term_r;
    if (cmd.step != khce_pkg::STEP_V0) begin
      if (sum > khce_pkg::SAT_LIM) begin
        sum = khce_pkg::SAT_LIM;
      end else if (sum < -khce_pkg::SAT_LIM) begin
        sum = -khce_pkg::SAT_LIM;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      khce_pkg::OP_START: t_r <= item.query_time;
      khce_pkg::OP_ZERO: begin
        curve_r  <= '0;
        status_r <= khce_pkg::ST_FEW;
      end
      khce_pkg::OP_SMALL: begin
        curve_r  <= rd_key.key_value;
        status_r <= khce_pkg::ST_FEW;
      end
      khce_pkg::OP_K0: begin
        t0_r    <= rd_key.key_time;
        v0_r    <= rd_key.key_value;
        tout0_r <= rd_key.tangent_out;
      end
      khce_pkg::OP_K1: begin
        t1_r   <= rd_key.key_time;
        v1_r   <= rd_key.key_value;
        tin1_r <= rd_key.tangent_in;
      end
      khce_pkg::OP_PREP: begin
        hmag_r  <= h_mag;
        h_neg_r <= h_full[32];
        q_neg_r <= h_full[32] ^ dt_full[32];
        rem_r   <= '0;
        q_r     <= {dt_mag, 16'd0};
      end
      khce_pkg::OP_HZ: begin
        curve_r  <= v0_r;
        status_r <= khce_pkg::ST_ZLEN;
      end
      khce_pkg::OP_DIV: begin
        rem_r <= div_ge ? 33'(rem_sh - {1'b0, hmag_r}) : rem_sh[32:0];
        q_r   <= {q_r[47:0], div_ge};
      end
      khce_pkg::OP_SFIN: begin
        smag_r  <= (q_r > khce_pkg::S_LIM) ? 32'h8000_0000 : q_r[31:0];
        s_neg_r <= q_neg_r;
      end
      khce_pkg::OP_M0: prod_r <= mul_p;
      khce_pkg::OP_M1: begin
        m0_r   <= (h_neg_r ^ tout0_r[31]) ? -p16 : p16;
        prod_r <= mul_p;
      end
      khce_pkg::OP_M1L: m1_r <= (h_neg_r ^ tin1_r[31]) ? -p16 : p16;
      khce_pkg::OP_COEF: begin
        c2_r  <= d + (d <<< 1) - (m0_r <<< 1) - m1_r;
        acc_r <= m0_r + m1_r - (d <<< 1);
      end
      khce_pkg::OP_HABS: begin
        amag_r  <= acc_r[63] ? 62'(-acc_r) : 62'(acc_r);
        a_neg_r <= acc_r[63];
      end
      khce_pkg::OP_HLO: prod_r <= mul_p;
      khce_pkg::OP_HHI: begin
        pl_r   <= prod_r[63:0];
        prod_r <= mul_p;
      end
      khce_pkg::OP_HCMB: term_r <= (a_neg_r ^ s_neg_r) ? -signed'(r_mag) : signed'(r_mag);
      khce_pkg::OP_HADD: acc_r <= sum;
      khce_pkg::OP_FIN: begin
        if (acc_r > khce_pkg::I32_MAX) begin
          curve_r <= 32'sh7FFF_FFFF;
        end else if (acc_r < khce_pkg::I32_MIN) begin
          curve_r <= -32'sh8000_0000;
        end else begin
          curve_r <= acc_r[31:0];
        end
        status_r <= khce_pkg::ST_OK;
      end
      default: ;
    endcase
  end

  assign sts.found  = rd_key.key_time >= t_r;
  assign sts.h_zero = (hmag_r == '0);
  assign curve_value = curve_r;
  assign status      = status_r;

endmodule

### design/khce_ctrl.sv
module khce_ctrl #(
  parameter int MAX_KEYS = 64,
  localparam int AW = $clog2(MAX_KEYS),
  localparam int NW = $clog2(MAX_KEYS + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_opcode,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  logic            cfg_we,
  input  logic [6:0]      cfg_wdata,
  input  khce_pkg::sts_t  sts,
  output khce_pkg::cmd_t  cmd,
  output logic [AW-1:0]   raddr
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_ZERO  = 5'd1;
  localparam logic [4:0] S_RD0   = 5'd2;
  localparam logic [4:0] S_SMALL = 5'd3;
  localparam logic [4:0] S_RD    = 5'd4;
  localparam logic [4:0] S_CMP   = 5'd5;
  localparam logic [4:0] S_F0    = 5'd6;
  localparam logic [4:0] S_F1    = 5'd7;
  localparam logic [4:0] S_F2    = 5'd8;
  localparam logic [4:0] S_PREP  = 5'd9;
  localparam logic [4:0] S_CHKH  = 5'd10;
  localparam logic [4:0] S_DIV   = 5'd11;
  localparam logic [4:0] S_SFIN  = 5'd12;
  localparam logic [4:0] S_M0    = 5'd13;
  localparam logic [4:0] S_M1    = 5'd14;
  localparam logic [4:0] S_M1L   = 5'd15;
  localparam logic [4:0] S_COEF  = 5'd16;
  localparam logic [4:0] S_HABS  = 5'd17;
  localparam logic [4:0] S_HLO   = 5'd18;
  localparam logic [4:0] S_HHI   = 5'd19;
  localparam logic [4:0] S_HCMB  = 5'd20;
  localparam logic [4:0] S_HADD  = 5'd21;
  localparam logic [4:0] S_FIN   = 5'd22;

  logic [4:0]    state_r, state_nxt;
  logic [6:0]    count_r, count_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] seg_r, seg_nxt;
  logic [5:0]    div_r, div_nxt;
  logic [1:0]    step_r, step_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [NW-1:0] n_c;
  logic          in_fire, out_free, res_load;

  assign n_c = (int'(count_r) > MAX_KEYS) ? NW'(MAX_KEYS) : NW'(count_r);
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    seg_nxt   = seg_r;
    div_nxt   = div_r;
    step_nxt  = step_r;
    res_load  = 1'b0;
    cmd.op    = khce_pkg::OP_NONE;
    cmd.step  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_opcode == khce_pkg::OPC_LOAD) begin
            cmd.op = khce_pkg::OP_LOAD;
          end else begin
            cmd.op  = khce_pkg::OP_START;
            cnt_nxt = '0;
            if (n_c == '0) begin
              state_nxt = S_ZERO;
            end else if (n_c == NW'(1)) begin
              state_nxt = S_RD0;
            end else begin
              state_nxt = S_RD;
            end
          end
        end
      end
      S_ZERO: begin
        if (out_free) begin
          cmd.op    = khce_pkg::OP_ZERO;
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RD0: state_nxt = S_SMALL;
      S_SMALL: begin
        if (out_free) begin
          cmd.op    = khce_pkg::OP_SMALL;
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RD: state_nxt = S_CMP;
      S_CMP: begin
        if (sts.found || (NW'(cnt_r) == n_c - NW'(1))) begin
          seg_nxt   = (cnt_r == '0) ? '0 : cnt_r - AW'(1);
          state_nxt = S_F0;
        end else begin
          cnt_nxt   = cnt_r + AW'(1);
          state_nxt = S_RD;
        end
      end
      S_F0: state_nxt = S_F1;
      S_F1: begin
        cmd.op    = khce_pkg::OP_K0;
        state_nxt = S_F2;
      end
      S_F2: begin
        cmd.op    = khce_pkg::OP_K1;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.op    = khce_pkg::OP_PREP;
        state_nxt = S_CHKH;
      end
      S_CHKH: begin
        if (sts.h_zero) begin
          if (out_free) begin
            cmd.op    = khce_pkg::OP_HZ;
            res_load  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          div_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.op = khce_pkg::OP_DIV;
        if (div_r == 6'(khce_pkg::DIV_BITS - 1)) begin
          state_nxt = S_SFIN;
        end else begin
          div_nxt = div_r + 6'd1;
        end
      end
      S_SFIN: begin
        cmd.op    = khce_pkg::OP_SFIN;
        state_nxt = S_M0;
      end
      S_M0: begin
        cmd.op    = khce_pkg::OP_M0;
        state_nxt = S_M1;
      end
      S_M1: begin
        cmd.op    = khce_pkg::OP_M1;
        state_nxt = S_M1L;
      end
      S_M1L: begin
        cmd.op    = khce_pkg::OP_M1L;
        state_nxt = S_COEF;
      end
      S_COEF: begin
        cmd.op    = khce_pkg::OP_COEF;
        step_nxt  = khce_pkg::STEP_C2;
        state_nxt = S_HABS;
      end
      S_HABS: begin
        cmd.op    = khce_pkg::OP_HABS;
        state_nxt = S_HLO;
      end
      S_HLO: begin
        cmd.op    = khce_pkg::OP_HLO;
        state_nxt = S_HHI;
      end
      S_HHI: begin
        cmd.op    = khce_pkg::OP_HHI;
        state_nxt = S_HCMB;
      end
      S_HCMB: begin
        cmd.op    = khce_pkg::OP_HCMB;
        state_nxt = S_HADD;
      end
      S_HADD: begin
        cmd.op = khce_pkg::OP_HADD;
        if (step_r == khce_pkg::STEP_V0) begin
          state_nxt = S_FIN;
        end else begin
          step_nxt  = step_r + 2'd1;
          state_nxt = S_HABS;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.op    = khce_pkg::OP_FIN;
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    case (state_r)
      S_RD:    raddr = cnt_r;
      S_F0:    raddr = seg_r;
      S_F1:    raddr = seg_r + AW'(1);
      default: raddr = '0;
    endcase
  end

  assign count_nxt = cfg_we ? cfg_wdata : count_r;
  assign out_valid_nxt = res_load ? 1'b1 : ((out_valid_r && out_ready) ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      seg_r       <= '0;
      div_r       <= '0;
      step_r      <= khce_pkg::STEP_C2;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      seg_r       <= seg_nxt;
      div_r       <= div_nxt;
      step_r      <= step_nxt;
    end
  end

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> NW'(cnt_r) < n_c)
    else $error("key scan ran past the key count");

  a_seg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_F1 |-> (NW'(seg_r) + NW'(1)) < n_c)
    else $error("segment end beyond key count");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SFIN |-> $past(state_r) == S_DIV && $past(div_r) == 6'(khce_pkg::DIV_BITS - 1))
    else $error("divide left early");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while held");

endmodule

### design/keyframe_hermite_curve_eval.sv
// Channel  | Dir | Payload                                           | Transfer
// in_if    | in  | opcode, key_index, key_time, key_value,           | valid & ready
//          |     | tangent_in, tangent_out, query_time               |
// out_if   | out | curve_value, status                               | valid & ready
// cfg      | in  | cfg_wdata (key_count)                             | cfg_we
//
// Load: no result. Query with n < 2 skips the table scan and the divider.
// Query: its time grows with k, the keys scanned (1..n), and is
//   set by the table scan per key (one RAM read port) and the
//   restoring divider. Zero-length segment skips the divider.
// Reset (rst_n low, synchronous) clears control and key_count; table is not cleared.
// One query in flight; a new transfer is taken once the result sits in the
//   output register, which holds under out_if.ready low.
module keyframe_hermite_curve_eval #(
  parameter int MAX_KEYS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  khce_in_if.sink     in_if,
  khce_out_if.source  out_if,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);

  localparam int AW = $clog2(MAX_KEYS);

  khce_pkg::cmd_t  cmd;
  khce_pkg::sts_t  sts;
  khce_pkg::item_t item;
  logic [AW-1:0]   raddr;

  // bundle the input payload for the datapath
  assign item = '{opcode: in_if.opcode, key_index: in_if.key_index,
                  key_time: in_if.key_time, key_value: in_if.key_value,
                  tangent_in: in_if.tangent_in, tangent_out: in_if.tangent_out,
                  query_time: in_if.query_time};

  // Sequencer: scan, segment fetch, divide, Horner steps, result handoff
  khce_ctrl #(.MAX_KEYS(MAX_KEYS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_opcode (in_if.opcode),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .cmd       (cmd),
    .raddr     (raddr)
  );

  // Key table, divider, shared multiplier and result register
  khce_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .raddr       (raddr),
    .item        (item),
    .sts         (sts),
    .curve_value (out_if.curve_value),
    .status      (out_if.status)
  );

endmodule
